// ----- rtl/rejection_sampler_lehmer_assert.svh -----
// assertion macros for the sampler checker
`ifndef REJECTION_SAMPLER_LEHMER_ASSERT_SVH
`define REJECTION_SAMPLER_LEHMER_ASSERT_SVH

// condition and consequence in the same cycle
`define RSL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sampler check failed");

// consequence in the cycle after the condition
`define RSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sampler check failed");

`endif

// ----- rtl/rsl_pkg.sv -----
`timescale 1ns / 1ps

package rsl_pkg;

  typedef logic [30:0] seed_t;
  typedef logic [1:0]  op_t;
  typedef logic [0:0]  cfg_idx_t;
  typedef logic [6:0]  bin_idx_t;
  typedef logic [27:0] q16_t;

  localparam op_t OP_WRITE  = 2'd0;
  localparam op_t OP_DRAW   = 2'd1;
  localparam op_t OP_RESEED = 2'd2;

  localparam cfg_idx_t CFG_SEED_FIRST  = 1'b0;
  localparam cfg_idx_t CFG_SEED_SECOND = 1'b1;

  localparam seed_t SEED_FIRST_RST  = 31'd1;
  localparam seed_t SEED_SECOND_RST = 31'd71;

  localparam logic [14:0] LEHMER_A = 15'd16807;
  localparam seed_t       LEHMER_M = 31'h7FFF_FFFF;
  localparam seed_t       SPLIT_Z  = 31'd702806974;
  localparam seed_t       KNEE_Z   = 31'((64'd91 * 64'd2147483647) / 64'd275);
  localparam logic [8:0]  SLOPE    = 9'd275;

  localparam q16_t LOW_BASE_Q16  = 28'd190054400;
  localparam q16_t HIGH_BASE_Q16 = 28'd195207168;
  localparam q16_t MAX_Q16       = 28'd197459968;

  localparam logic [15:0] LOW_H    = 16'd5000;
  localparam logic [15:0] HIGH_H   = 16'd40000;
  localparam logic [11:0] BIN_BASE = 12'd2900;

  localparam int PROD_W = 40;
  localparam int Z2H_W  = 47;
  localparam int NUM_W  = 56;
  localparam int QUO_W  = 25;

  typedef struct packed {
    logic     we;
    cfg_idx_t idx;
    seed_t    data;
  } cfg_wr_t;

  typedef struct packed {
    logic advance;
    logic reseed;
  } gen_ctl_t;

endpackage

// ----- rtl/rsl_ram.sv -----
`timescale 1ns / 1ps

module rsl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 114
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rsl_gen.sv -----
`timescale 1ns / 1ps

module rsl_gen (
  input  logic              clk,
  input  logic              rst,
  input  rsl_pkg::cfg_wr_t  cfg,
  input  rsl_pkg::gen_ctl_t ctl,
  output rsl_pkg::seed_t    z1_next,
  output rsl_pkg::seed_t    z2_next
);

  import rsl_pkg::*;

  seed_t seed1;
  seed_t seed2;
  seed_t gen1;
  seed_t gen2;

  // z * a mod (2^31 - 1) by folding the high part onto the low part
  function automatic seed_t lehmer_next(input seed_t z);
    logic [45:0] p;
    logic [31:0] s;
    begin
      p = 46'(z) * 46'(LEHMER_A);
      s = 32'(p[30:0]) + 32'(p[45:31]);
      if (s >= 32'(LEHMER_M)) begin
        s = s - 32'(LEHMER_M);
      end
      return s[30:0];
    end
  endfunction

  assign z1_next = lehmer_next(gen1);
  assign z2_next = lehmer_next(gen2);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed1 <= SEED_FIRST_RST;
      seed2 <= SEED_SECOND_RST;
      gen1  <= SEED_FIRST_RST;
      gen2  <= SEED_SECOND_RST;
    end else begin
      if (cfg.we) begin
        unique case (cfg.idx)
          CFG_SEED_FIRST:  seed1 <= cfg.data;
          CFG_SEED_SECOND: seed2 <= cfg.data;
          default: ;
        endcase
      end
      if (ctl.reseed) begin
        gen1 <= seed1;
        gen2 <= seed2;
      end else if (ctl.advance) begin
        gen1 <= z1_next;
        gen2 <= z2_next;
      end
    end
  end

endmodule

// ----- rtl/rejection_sampler_lehmer.sv -----
`timescale 1ns / 1ps
// Acceptance-rejection sampler over a histogram, driven by two Lehmer generators.
// Channels:
//   config: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
//           index 0 loads seed_first, index 1 loads seed_second.
//   input:  in_valid/in_ready with opcode, bin_index, bin_height.
//           opcode 0 writes a bin height, 1 draws a candidate, 2 reloads the
//           generators from the seeds; 3 is ignored.
//   output: out_valid/out_ready with sample_q16, accepted, chosen_bin,
//           one transfer per draw and none for any other opcode.
// Path: a draw passes the input register, stages 1 to 4 and the output register.
// Throughput: one item per cycle while the receiver takes each result; the
// generator step (multiply and fold) sits in a single stage so draws follow each other with no gap.
// Bin heights live in a registered-read RAM with a per-bin loaded flag.
// Reset: seeds and generators go to 1 and 71, all bins read as zero.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// in_ready drops only once every stage holds an item.
module rejection_sampler_lehmer #(
  parameter int NUM_BINS    = 114,
  parameter int HEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  rsl_pkg::cfg_idx_t cfg_index,
  input  rsl_pkg::seed_t    cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsl_pkg::op_t      opcode,
  input  rsl_pkg::bin_idx_t bin_index,
  input  logic [15:0]       bin_height,
  output logic              out_valid,
  input  logic              out_ready,
  output rsl_pkg::q16_t     sample_q16,
  output logic              accepted,
  output rsl_pkg::bin_idx_t chosen_bin
);

  import rsl_pkg::*;

  localparam int ADDR_W = $clog2(NUM_BINS);
  localparam int HM_W   = HEIGHT_BITS + 31;
  localparam int CMP_W  = (HM_W > Z2H_W) ? HM_W : Z2H_W;

  cfg_wr_t  cfg_wr;
  gen_ctl_t gen_ctl;
  seed_t    z1_next;
  seed_t    z2_next;

  // stage 0: input register
  logic        v0;
  op_t         op0;
  bin_idx_t    idx0;
  logic [15:0] hgt0;
  logic        keep0;
  logic        adv0;

  // stage 1: fresh generator values
  logic        v1;
  op_t         op1;
  bin_idx_t    idx1;
  logic [15:0] hgt1;
  seed_t       z1_1;
  seed_t       z2_1;
  logic        rdy1;
  logic        adv1;
  logic [PROD_W-1:0] p1;
  logic [Z2H_W-1:0]  z2h1;

  // stage 2: products
  logic        v2;
  op_t         op2;
  bin_idx_t    idx2;
  logic [15:0] hgt2;
  logic [PROD_W-1:0] p2;
  logic        low2;
  logic [Z2H_W-1:0]  z2h2;
  logic        rdy2;
  logic        adv2;
  logic [NUM_W-1:0]  n2;
  logic [31:0]       sum2;
  logic [QUO_W-1:0]  quo2;
  q16_t        q16_2;

  // stage 3: candidate position, memory access
  logic        v3;
  op_t         op3;
  bin_idx_t    idx3;
  logic [15:0] hgt3;
  q16_t        q16_3;
  logic [Z2H_W-1:0]  z2h3;
  logic        rdy3;
  logic        adv3;
  logic [11:0] binw3;
  logic        inr3;
  logic [ADDR_W-1:0] rd_addr;
  logic        ram_we;
  logic        ram_re;

  // stage 4: bin height read back
  logic        v4;
  q16_t        q16_4;
  bin_idx_t    bin4;
  logic        inr4;
  logic        vld4;
  logic [Z2H_W-1:0]  z2h4;
  logic        rdy4;
  logic        adv4;
  logic [HEIGHT_BITS-1:0] rd_data;
  logic [HEIGHT_BITS-1:0] hgt4;
  logic [CMP_W-1:0]       hm4;
  logic        acc4;
  logic        rdy5;

  logic [NUM_BINS-1:0] loaded;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = '{we: cfg_valid, idx: cfg_index, data: cfg_data};

  // stage 0
  assign keep0    = (op0 == OP_WRITE) || (op0 == OP_DRAW);
  assign adv0     = v0 && (rdy1 || !keep0);
  assign in_ready = !v0 || adv0;
  assign gen_ctl  = '{advance: adv0 && (op0 == OP_DRAW),
                      reseed:  adv0 && (op0 == OP_RESEED)};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ready) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op0  <= opcode;
      idx0 <= bin_index;
      hgt0 <= bin_height;
    end
  end

  rsl_gen u_gen (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_wr),
    .ctl     (gen_ctl),
    .z1_next (z1_next),
    .z2_next (z2_next)
  );

  // stage 1
  assign adv1 = v1 && rdy2;
  assign rdy1 = !v1 || adv1;
  assign p1   = PROD_W'(z1_1) * PROD_W'(SLOPE);
  assign z2h1 = Z2H_W'(z2_1) * Z2H_W'((z1_1 <= KNEE_Z) ? LOW_H : HIGH_H);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv0 && keep0) begin
      v1 <= 1'b1;
    end else if (adv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && keep0) begin
      op1  <= op0;
      idx1 <= idx0;
      hgt1 <= hgt0;
      z1_1 <= z1_next;
      z2_1 <= z2_next;
    end
  end

  // stage 2: divide by 2^31 - 1 as quotient a plus a carry from a + b
  assign adv2  = v2 && rdy3;
  assign rdy2  = !v2 || adv2;
  assign n2    = low2 ? {p2, 16'b0} : {3'b0, p2, 13'b0};
  assign sum2  = 32'(n2[30:0]) + 32'(n2[NUM_W-1:31]);
  assign quo2  = n2[NUM_W-1:31] + QUO_W'(sum2 >= 32'(LEHMER_M));
  assign q16_2 = (low2 ? LOW_BASE_Q16 : HIGH_BASE_Q16) + 28'(quo2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv1) begin
      v2 <= 1'b1;
    end else if (adv2) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      op2  <= op1;
      idx2 <= idx1;
      hgt2 <= hgt1;
      p2   <= p1;
      low2 <= (z1_1 < SPLIT_Z);
      z2h2 <= z2h1;
    end
  end

  // stage 3
  assign adv3    = v3 && ((op3 == OP_WRITE) || rdy4);
  assign rdy3    = !v3 || adv3;
  assign binw3   = q16_3[27:16] - BIN_BASE;
  assign inr3    = (q16_3[27:16] >= BIN_BASE) && (binw3 < 12'(NUM_BINS));
  assign rd_addr = inr3 ? binw3[ADDR_W-1:0] : '0;
  assign ram_we  = adv3 && (op3 == OP_WRITE) && ({1'b0, idx3} < 8'(NUM_BINS));
  assign ram_re  = adv3 && (op3 == OP_DRAW);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv2) begin
      v3 <= 1'b1;
    end else if (adv3) begin
      v3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      op3   <= op2;
      idx3  <= idx2;
      hgt3  <= hgt2;
      q16_3 <= q16_2;
      z2h3  <= z2h2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (ram_we) begin
      loaded[idx3[ADDR_W-1:0]] <= 1'b1;
    end
  end

  rsl_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx3[ADDR_W-1:0]),
    .wdata (HEIGHT_BITS'(hgt3)),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // stage 4: z2 * H < height * M
  assign rdy5 = !out_valid || out_ready;
  assign adv4 = v4 && rdy5;
  assign rdy4 = !v4 || adv4;
  assign hgt4 = vld4 ? rd_data : '0;
  assign hm4  = (CMP_W'(hgt4) << 31) - CMP_W'(hgt4);
  assign acc4 = inr4 && (CMP_W'(z2h4) < hm4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ram_re) begin
      v4 <= 1'b1;
    end else if (adv4) begin
      v4 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      q16_4 <= q16_3;
      bin4  <= binw3[6:0];
      inr4  <= inr3;
      vld4  <= loaded[rd_addr];
      z2h4  <= z2h3;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      sample_q16 <= q16_4;
      accepted   <= acc4;
      chosen_bin <= bin4;
    end
  end

endmodule

// ----- rtl/rsl_checker.sv -----
`timescale 1ns / 1ps
`include "rejection_sampler_lehmer_assert.svh"

module rsl_checker #(
  parameter int NUM_BINS = 114
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input rsl_pkg::q16_t     sample_q16,
  input logic              accepted,
  input rsl_pkg::bin_idx_t chosen_bin
);

  import rsl_pkg::*;

  logic [35:0] out_word;

  assign out_word = {sample_q16, accepted, chosen_bin};

  // a stalled result holds
  `RSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // bin follows from the integer part of the position
  `RSL_ASSERT_SAME(a_bin_match, out_valid, chosen_bin == 7'(sample_q16[27:16] - BIN_BASE))

  // position stays inside the envelope
  `RSL_ASSERT_SAME(a_pos_range, out_valid, (sample_q16 >= LOW_BASE_Q16) && (sample_q16 <= MAX_Q16))

  // only a real bin can accept
  `RSL_ASSERT_SAME(a_acc_bin, out_valid && accepted, 32'(chosen_bin) < 32'(NUM_BINS))

endmodule

bind rejection_sampler_lehmer rsl_checker #(.NUM_BINS(NUM_BINS)) u_checker (.*);
